/* rtl/tpmv_pkg.sv */
// tpmv_pkg: shared types and codes for the triangular packed matrix-vector unit
// used by tpmv_cell, tpmv_mac and triangular_packed_matvec
`default_nettype none
package tpmv_pkg;
	localparam int CMD_W = 2;
	localparam int INDEX_W = 12;
	localparam int ELEMENT_W = 6;
	localparam int ORDER_W = 7;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_MATRIX = 2'd0,
		CMD_LOAD_VECTOR = 2'd1,
		CMD_RUN         = 2'd2,
		CMD_NONE        = 2'd3
	} tpmv_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER      = 2'd0,
		REG_TRANSPOSED = 2'd1,
		REG_UNIT_DIAG  = 2'd2,
		REG_ORDER      = 2'd3
	} tpmv_reg_t;

	typedef struct packed {
		logic load;
		logic rotate;
		logic copy;
		logic shift;
	} tpmv_cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/tpmv_cell.sv */
// tpmv_cell: one vector cell holding an operand element and a result element
// depends on tpmv_pkg
`default_nettype none
module tpmv_cell #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire tpmv_pkg::tpmv_cell_ctl_t ctl,
	input  wire logic [VALUE_WIDTH-1:0] load_value,
	input  wire logic [VALUE_WIDTH-1:0] x_in,
	input  wire logic [VALUE_WIDTH-1:0] r_in,
	output logic      [VALUE_WIDTH-1:0] x_out,
	output logic      [VALUE_WIDTH-1:0] r_out
);
	import tpmv_pkg::*;

	logic [VALUE_WIDTH-1:0] x_q;
	logic [VALUE_WIDTH-1:0] r_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= load_value;
		end else if (ctl.rotate) begin
			x_q <= x_in;
		end else if (ctl.copy) begin
			x_q <= r_q;
		end
		if (ctl.shift) begin
			r_q <= r_in;
		end
	end

	assign x_out = x_q;
	assign r_out = r_q;
endmodule
`default_nettype wire

/* rtl/tpmv_mac.sv */
// tpmv_mac: multiply, wide accumulate, truncate and saturate one row at a time
// depends on tpmv_pkg
`default_nettype none
module tpmv_mac #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 24
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid_s1,
	input  wire logic                   inside_s1,
	input  wire logic                   unit_s1,
	input  wire logic                   first_s1,
	input  wire logic                   last_s1,
	input  wire logic [VALUE_WIDTH-1:0] a_s1,
	input  wire logic [VALUE_WIDTH-1:0] x_s1,
	output logic                        push,
	output logic      [VALUE_WIDTH-1:0] result
);
	import tpmv_pkg::*;

	localparam int PW = 2 * VALUE_WIDTH;
	localparam int ACC_W = PW + 11;

	logic signed [PW-1:0] prod;
	logic [ACC_W-1:0] xext;
	logic [ACC_W-1:0] term_s2;
	logic valid_s2, first_s2, last_s2;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0] sum_s3;
	logic push_s3;
	logic [ACC_W-1:0] shr;
	logic [ACC_W-VALUE_WIDTH:0] hi;

	assign prod = $signed(a_s1) * $signed(x_s1);
	assign xext = {{(ACC_W-VALUE_WIDTH){x_s1[VALUE_WIDTH-1]}}, x_s1};

	always_ff @(posedge clk) begin
		if (!inside_s1) begin
			term_s2 <= '0;
		end else if (unit_s1) begin
			term_s2 <= xext << FRACTION_BITS;
		end else begin
			term_s2 <= {{(ACC_W-PW){prod[PW-1]}}, prod};
		end
		first_s2 <= first_s1;
		last_s2 <= last_s1;
		acc_q <= acc_next;
		sum_s3 <= acc_next;
	end

	assign acc_next = (first_s2 ? '0 : acc_q) + term_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			push_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			push_s3 <= valid_s2 & last_s2;
		end
	end

	assign shr = $signed(sum_s3) >>> FRACTION_BITS;
	assign hi = shr[ACC_W-1:VALUE_WIDTH-1];

	always_comb begin
		if ((&hi) || !(|hi)) begin
			result = shr[VALUE_WIDTH-1:0];
		end else if (shr[ACC_W-1]) begin
			result = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
		end else begin
			result = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end
	end

	assign push = push_s3;
endmodule
`default_nettype wire

/* rtl/triangular_packed_matvec.sv */
// triangular_packed_matvec: x := A*x or A^T*x with A triangular and packed by column
// load items are accepted while idle; a run issues a term per matrix element,
// then drains the multiply-accumulate, copies results over x and streams n results
// one multiply-accumulate unit and a one-read packed memory take one term at a time
// arst_n resets control and config; matrix, vector stores are undefined until written
// depends on tpmv_pkg, tpmv_cell, tpmv_mac
`default_nettype none
module triangular_packed_matvec #(
	parameter int MAX_ORDER     = 64,
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// index, value
	input  wire logic [((tpmv_pkg::INDEX_W+VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
	// command
	input  wire logic [tpmv_pkg::CMD_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// element, product
	output logic [((tpmv_pkg::ELEMENT_W+VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic                               m_tlast,
	input  wire logic                          cfg_we,
	input  wire logic [tpmv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tpmv_pkg::ORDER_W-1:0]  cfg_data
);
	import tpmv_pkg::*;

	localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(MAX_ORDER + 1);
	localparam int IW = MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1;
	localparam int MW = 2 * NW + 2;
	localparam int OUT_W = ((ELEMENT_W + VALUE_WIDTH + 7) / 8) * 8;

	typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_COPY, S_OUT} state_t;

	state_t state_q;
	logic upper_q, transposed_q, unit_q;
	logic [ORDER_W-1:0] order_q;
	logic [NW-1:0] n_q, nm1;
	logic [IW-1:0] r_q, k_q, p_q, o_q;

	logic [INDEX_W-1:0] idx;
	logic [VALUE_WIDTH-1:0] val;
	logic accept;

	logic [VALUE_WIDTH-1:0] mem [DEPTH];
	logic [VALUE_WIDTH-1:0] a_s1, x_s1;
	logic valid_s1, inside_s1, unit_s1, first_s1, last_s1;

	logic [IW-1:0] ii, jj;
	logic [MW-1:0] im, jm, nm, addr_w;
	logic issue, push;
	logic [VALUE_WIDTH-1:0] result;
	logic row_end, out_hs;

	logic [VALUE_WIDTH-1:0] xv [MAX_ORDER];
	logic [VALUE_WIDTH-1:0] rv [MAX_ORDER];

	assign idx = s_tdata[INDEX_W-1:0];
	assign val = s_tdata[INDEX_W+VALUE_WIDTH-1:INDEX_W];
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid & s_tready;
	assign nm1 = n_q - NW'(1);
	assign issue = (state_q == S_RUN);
	assign row_end = (NW'(k_q) == nm1);
	assign out_hs = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= 1'b1;
			transposed_q <= 1'b0;
			unit_q <= 1'b0;
			order_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UPPER: upper_q <= cfg_data[0];
				REG_TRANSPOSED: transposed_q <= cfg_data[0];
				REG_UNIT_DIAG: unit_q <= cfg_data[0];
				REG_ORDER: order_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			r_q <= '0;
			k_q <= '0;
			p_q <= '0;
			o_q <= '0;
		end else begin
			if (push) begin
				p_q <= p_q + IW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == CMD_RUN && order_q != '0) begin
						n_q <= (32'(order_q) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order_q);
						r_q <= '0;
						k_q <= '0;
						p_q <= '0;
						o_q <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (row_end) begin
						k_q <= '0;
						r_q <= r_q + IW'(1);
						if (NW'(r_q) == nm1) begin
							state_q <= S_DRAIN;
						end
					end else begin
						k_q <= k_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (push && NW'(p_q) == nm1) begin
						state_q <= S_COPY;
					end
				end
				S_COPY: state_q <= S_OUT;
				S_OUT: begin
					if (out_hs) begin
						o_q <= o_q + IW'(1);
						if (NW'(o_q) == nm1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ii = transposed_q ? k_q : r_q;
	assign jj = transposed_q ? r_q : k_q;
	assign im = MW'(ii);
	assign jm = MW'(jj);
	assign nm = MW'(n_q);

	always_comb begin
		if (upper_q) begin
			addr_w = ((jm * (jm + MW'(1))) >> 1) + im;
		end else begin
			addr_w = ((jm * ((nm << 1) - jm + MW'(1))) >> 1) + im - jm;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tuser == CMD_LOAD_MATRIX && 32'(idx) < DEPTH) begin
			mem[AW'(idx)] <= val;
		end
		a_s1 <= mem[AW'(addr_w)];
	end

	always_ff @(posedge clk) begin
		x_s1 <= xv[0];
		inside_s1 <= upper_q ? (ii <= jj) : (ii >= jj);
		unit_s1 <= unit_q && (ii == jj);
		first_s1 <= (k_q == '0);
		last_s1 <= row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	tpmv_mac #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.inside_s1(inside_s1),
		.unit_s1(unit_s1),
		.first_s1(first_s1),
		.last_s1(last_s1),
		.a_s1(a_s1),
		.x_s1(x_s1),
		.push(push),
		.result(result)
	);

	for (genvar i = 0; i < MAX_ORDER; i++) begin : g_cell
		tpmv_cell_ctl_t ctl;
		logic active, at_end;
		logic [VALUE_WIDTH-1:0] x_in, r_in;

		assign active = (i < 32'(n_q));
		assign at_end = (i == 32'(nm1));
		assign ctl.load = accept && s_tuser == CMD_LOAD_VECTOR && 32'(idx) == i;
		assign ctl.rotate = issue && active;
		assign ctl.copy = (state_q == S_COPY) && active;
		assign ctl.shift = (push || out_hs) && active;

		if (i == MAX_ORDER - 1) begin : g_tail
			assign x_in = xv[0];
			assign r_in = result;
		end else begin : g_body
			assign x_in = at_end ? xv[0] : xv[i+1];
			assign r_in = at_end ? result : rv[i+1];
		end

		tpmv_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.load_value(val),
			.x_in(x_in),
			.r_in(r_in),
			.x_out(xv[i]),
			.r_out(rv[i])
		);
	end

	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = OUT_W'({rv[0], ELEMENT_W'(o_q)});
	assign m_tlast = (NW'(o_q) == nm1);
endmodule
`default_nettype wire
